>>> sv/pcl_pkg.sv
// Shared types, widths and constants of the palette color lookup block.
// Used by the channel interfaces, the blend unit and the core; depends on nothing.
package pcl_pkg;

	localparam int MAX_ENTRIES_DEF      = 64;
	localparam int SAMPLE_FRACTION_BITS = 14;

	localparam int KIND_W    = 1;
	localparam int INDEX_W   = 6;
	localparam int VALUE_W   = 16;
	localparam int COLOR_W   = 8;
	localparam int SEGMENT_W = 6;
	localparam int COUNT_W   = 7;

	// Internal arithmetic widths, sized to the ranges of the scalars.
	localparam int SMP_W  = 17;
	localparam int DIFF_W = 17;
	localparam int OFF_W  = 18;
	localparam int DOFF_W = 19;
	localparam int MULB_W = 9;
	localparam int PROD_W = 28;
	localparam int ACC_W  = 29;
	localparam int MAG_W  = 28;
	localparam int DMAG_W = 16;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register index as seen in paddr[2].
	localparam logic REG_ENTRY_COUNT = 1'b0;

	localparam logic signed [31:0] SAMPLE_POS_ONE = 32'sd1 <<< SAMPLE_FRACTION_BITS;
	localparam logic signed [31:0] SAMPLE_NEG_ONE = -SAMPLE_POS_ONE;

	localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [COLOR_W-1:0] ALPHA_CLEAR  = 8'h00;
	localparam logic [COLOR_W-1:0] COLOR_MAX    = 8'hFF;
	localparam logic [COLOR_W-1:0] COLOR_ZERO   = 8'h00;

	localparam logic [1:0] COMP_FIRST = 2'd0;
	localparam logic [1:0] COMP_LAST  = 2'd2;

	typedef enum logic {
		KIND_LOAD   = 1'b0,
		KIND_LOOKUP = 1'b1
	} kind_t;

	typedef struct packed {
		logic                      none;
		logic [COLOR_W-1:0]        red;
		logic [COLOR_W-1:0]        green;
		logic [COLOR_W-1:0]        blue;
		logic signed [VALUE_W-1:0] value;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_CHECK,
		ST_SCAN,
		ST_UPPER,
		ST_LOWER,
		ST_DECIDE,
		ST_BLEND,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [2:0] {
		BL_IDLE,
		BL_MUL_A,
		BL_MUL_B,
		BL_SETUP,
		BL_DIV,
		BL_FIN
	} blend_state_t;

	// Component 0 is red, 1 green, 2 blue.
	typedef struct packed {
		logic signed [DIFF_W-1:0] diff;
		logic signed [OFF_W-1:0]  off;
		logic signed [DOFF_W-1:0] doff;
		logic [2:0][COLOR_W-1:0]  above;
		logic [2:0][COLOR_W-1:0]  below;
	} blend_req_t;

	typedef struct packed {
		logic                    done;
		logic [2:0][COLOR_W-1:0] color;
	} blend_rsp_t;

endpackage

>>> sv/pcl_req_if.sv
// Input channel of the palette color lookup block: load and lookup items.
// Depends on pcl_pkg for field widths.
interface pcl_req_if;
	logic                               valid;
	logic                               ready;
	logic [pcl_pkg::KIND_W-1:0]         kind;
	logic [pcl_pkg::INDEX_W-1:0]        entry_index;
	logic signed [pcl_pkg::VALUE_W-1:0] entry_value;
	logic [pcl_pkg::COLOR_W-1:0]        entry_red;
	logic [pcl_pkg::COLOR_W-1:0]        entry_green;
	logic [pcl_pkg::COLOR_W-1:0]        entry_blue;
	logic                               entry_none;
	logic signed [pcl_pkg::VALUE_W-1:0] sample;
	logic                               interpolate;

	modport source (
		output valid, kind, entry_index, entry_value, entry_red, entry_green,
		       entry_blue, entry_none, sample, interpolate,
		input  ready
	);

	modport sink (
		input  valid, kind, entry_index, entry_value, entry_red, entry_green,
		       entry_blue, entry_none, sample, interpolate,
		output ready
	);
endinterface

>>> sv/pcl_rsp_if.sv
// Output channel of the palette color lookup block: one color item per lookup.
// Depends on pcl_pkg for field widths.
interface pcl_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [pcl_pkg::COLOR_W-1:0]   red;
	logic [pcl_pkg::COLOR_W-1:0]   green;
	logic [pcl_pkg::COLOR_W-1:0]   blue;
	logic [pcl_pkg::COLOR_W-1:0]   alpha;
	logic [pcl_pkg::SEGMENT_W-1:0] segment;

	modport source (
		output valid, red, green, blue, alpha, segment,
		input  ready
	);

	modport sink (
		input  valid, red, green, blue, alpha, segment,
		output ready
	);
endinterface

>>> sv/pcl_blend_unit.sv
// Color blend unit: one shared multiplier and a restoring divider, run for
// red, green and blue in turn. Depends on pcl_pkg.
module pcl_blend_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pcl_pkg::blend_req_t req,
	output pcl_pkg::blend_rsp_t rsp
);

	pcl_pkg::blend_state_t state_q, state_d;

	logic signed [pcl_pkg::OFF_W-1:0]  off_q;
	logic signed [pcl_pkg::DOFF_W-1:0] doff_q;
	logic [pcl_pkg::DMAG_W-1:0]        dmag_q;
	logic                              dneg_q;
	logic [2:0][pcl_pkg::COLOR_W-1:0]  above_q;
	logic [2:0][pcl_pkg::COLOR_W-1:0]  below_q;
	logic [1:0]                        comp_q;
	logic signed [pcl_pkg::ACC_W-1:0]  acc_q;
	logic [pcl_pkg::MAG_W-1:0]         rem_q;
	logic [pcl_pkg::MAG_W-1:0]         dsh_q;
	logic [pcl_pkg::COLOR_W-1:0]       quo_q;
	logic [2:0]                        cnt_q;
	logic                              big_q;
	logic                              qneg_q;
	logic [2:0][pcl_pkg::COLOR_W-1:0]  res_q;
	logic                              done_q;

	logic signed [pcl_pkg::DOFF_W-1:0] mul_a;
	logic signed [pcl_pkg::MULB_W-1:0] mul_b;
	logic signed [pcl_pkg::PROD_W-1:0] prod;
	logic signed [pcl_pkg::ACC_W-1:0]  acc_abs;
	logic [pcl_pkg::MAG_W-1:0]         acc_mag;
	logic [pcl_pkg::MAG_W-1:0]         dlim;
	logic signed [pcl_pkg::DIFF_W-1:0] diff_abs;
	logic                              rem_ge;
	logic [pcl_pkg::COLOR_W-1:0]       fin_val;

	// The single multiplier: offset times upper color, then the remaining
	// distance times lower color, accumulated in acc_q.
	always_comb begin
		if (state_q == pcl_pkg::BL_MUL_B) begin
			mul_a = doff_q;
			mul_b = $signed({1'b0, below_q[comp_q]});
		end else begin
			mul_a = pcl_pkg::DOFF_W'(off_q);
			mul_b = $signed({1'b0, above_q[comp_q]});
		end
		prod = mul_a * mul_b;
	end

	assign acc_abs  = acc_q[pcl_pkg::ACC_W-1] ? -acc_q : acc_q;
	assign acc_mag  = pcl_pkg::MAG_W'(acc_abs);
	assign dlim     = pcl_pkg::MAG_W'({dmag_q, 8'b0});
	assign diff_abs = req.diff[pcl_pkg::DIFF_W-1] ? -req.diff : req.diff;
	assign rem_ge   = rem_q >= dsh_q;

	// A negative quotient saturates to zero, one of 256 or more to full scale.
	assign fin_val = qneg_q ? pcl_pkg::COLOR_ZERO : (big_q ? pcl_pkg::COLOR_MAX : quo_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pcl_pkg::BL_IDLE:  if (start) state_d = pcl_pkg::BL_MUL_A;
			pcl_pkg::BL_MUL_A: state_d = pcl_pkg::BL_MUL_B;
			pcl_pkg::BL_MUL_B: state_d = pcl_pkg::BL_SETUP;
			pcl_pkg::BL_SETUP: state_d = pcl_pkg::BL_DIV;
			pcl_pkg::BL_DIV:   if (cnt_q == 3'd7) state_d = pcl_pkg::BL_FIN;
			pcl_pkg::BL_FIN: begin
				if (comp_q == pcl_pkg::COMP_LAST) state_d = pcl_pkg::BL_IDLE;
				else state_d = pcl_pkg::BL_MUL_A;
			end
			default: state_d = pcl_pkg::BL_IDLE;
		endcase
	end

	always_comb begin
		rsp.done  = done_q;
		rsp.color = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcl_pkg::BL_IDLE;
			comp_q  <= pcl_pkg::COMP_FIRST;
			cnt_q   <= 3'd0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == pcl_pkg::BL_FIN) && (comp_q == pcl_pkg::COMP_LAST);
			if (state_q == pcl_pkg::BL_IDLE && start) comp_q <= pcl_pkg::COMP_FIRST;
			else if (state_q == pcl_pkg::BL_FIN) comp_q <= comp_q + 2'd1;
			if (state_q == pcl_pkg::BL_SETUP) cnt_q <= 3'd0;
			else if (state_q == pcl_pkg::BL_DIV) cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pcl_pkg::BL_IDLE: begin
				if (start) begin
					off_q   <= req.off;
					doff_q  <= req.doff;
					dmag_q  <= pcl_pkg::DMAG_W'(diff_abs);
					dneg_q  <= req.diff[pcl_pkg::DIFF_W-1];
					above_q <= req.above;
					below_q <= req.below;
				end
			end
			pcl_pkg::BL_MUL_A: acc_q <= pcl_pkg::ACC_W'(prod);
			pcl_pkg::BL_MUL_B: acc_q <= acc_q + pcl_pkg::ACC_W'(prod);
			pcl_pkg::BL_SETUP: begin
				// The quotient fits in eight bits unless it saturates anyway.
				rem_q  <= acc_mag;
				dsh_q  <= pcl_pkg::MAG_W'({dmag_q, 7'b0});
				quo_q  <= '0;
				big_q  <= acc_mag >= dlim;
				qneg_q <= acc_q[pcl_pkg::ACC_W-1] ^ dneg_q;
			end
			pcl_pkg::BL_DIV: begin
				if (rem_ge) rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[pcl_pkg::COLOR_W-2:0], rem_ge};
				dsh_q <= dsh_q >> 1;
			end
			pcl_pkg::BL_FIN: res_q[comp_q] <= fin_val;
			default: ;
		endcase
	end

endmodule

>>> sv/palette_color_lookup_core.sv
// Palette color lookup core. A load item is written to the palette and the block stays ready.
// A lookup reads the first and the last entry, scans the entries in between where needed,
// reads the chosen entry and the one below it, and with blending runs the shared multiply/divide
// unit once per color component; the scan reads one entry a cycle. A lookup holds the input
// until its result is loaded into the output register, which waits while that register is full.
// Reset clears the control state and entry_count; palette entries are undefined until loaded.
module palette_color_lookup_core #(
	parameter int MAX_ENTRIES = pcl_pkg::MAX_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pcl_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [pcl_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [pcl_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	pcl_req_if.sink                          req,
	pcl_rsp_if.source                        rsp
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	pcl_pkg::ctrl_state_t state_q, state_d;

	logic [pcl_pkg::COUNT_W-1:0]          entry_count_q;
	pcl_pkg::entry_t                      entry_mem_q [MAX_ENTRIES];
	pcl_pkg::entry_t                      rdata_q;
	pcl_pkg::entry_t                      upper_q;
	pcl_pkg::entry_t                      wr_entry;
	logic [IDX_W-1:0]                     raddr;
	logic [IDX_W-1:0]                     waddr;
	logic                                 mem_we;

	logic signed [pcl_pkg::SMP_W-1:0]     s_q;
	logic                                 interp_q;
	logic [CNT_W-1:0]                     n_q;
	logic signed [pcl_pkg::VALUE_W-1:0]   v0_q;
	logic [IDX_W-1:0]                     i_q;
	logic [IDX_W-1:0]                     idx_q;

	logic [pcl_pkg::COLOR_W-1:0]          red_q, green_q, blue_q, alpha_q;
	logic [pcl_pkg::SEGMENT_W-1:0]        seg_q;
	logic                                 out_valid_q;
	logic [pcl_pkg::COLOR_W-1:0]          out_red_q, out_green_q, out_blue_q, out_alpha_q;
	logic [pcl_pkg::SEGMENT_W-1:0]        out_seg_q;

	logic                                 req_fire;
	logic                                 is_lookup;
	logic [31:0]                          cnt_ext;
	logic [CNT_W-1:0]                     n_eff;
	logic signed [31:0]                   smp_wide;
	logic signed [31:0]                   smp_clamp;
	logic signed [pcl_pkg::VALUE_W-1:0]   rd_v;
	logic                                 chk_top, chk_bottom, chk_pair, chk_scan;
	logic                                 scan_stop;
	logic                                 has_below;
	logic signed [pcl_pkg::DIFF_W-1:0]    diff_c;
	logic signed [pcl_pkg::OFF_W-1:0]     off_c;
	logic signed [pcl_pkg::DOFF_W-1:0]    doff_c;
	logic                                 blend_go;
	logic                                 blend_start;
	logic                                 out_load;
	logic                                 cfg_we;
	pcl_pkg::blend_req_t                  blend_req;
	pcl_pkg::blend_rsp_t                  blend_rsp;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == pcl_pkg::REG_ENTRY_COUNT);
	assign prdata = (paddr[2] == pcl_pkg::REG_ENTRY_COUNT) ?
	                pcl_pkg::APB_DATA_W'(entry_count_q) : '0;

	// Input decode.
	assign req_fire  = req.valid && req.ready;
	assign is_lookup = req.kind == pcl_pkg::KIND_LOOKUP;
	assign cnt_ext   = 32'(entry_count_q);
	assign n_eff     = CNT_W'((cnt_ext > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : cnt_ext);
	assign smp_wide  = 32'(req.sample);

	always_comb begin
		smp_clamp = smp_wide;
		if (smp_wide < pcl_pkg::SAMPLE_NEG_ONE) smp_clamp = pcl_pkg::SAMPLE_NEG_ONE;
		if (smp_wide > pcl_pkg::SAMPLE_POS_ONE) smp_clamp = pcl_pkg::SAMPLE_POS_ONE;
	end

	assign mem_we = req_fire && !is_lookup && (32'(req.entry_index) < 32'(MAX_ENTRIES));
	assign waddr  = IDX_W'(req.entry_index);
	assign wr_entry = '{none: req.entry_none, red: req.entry_red, green: req.entry_green,
	                    blue: req.entry_blue, value: req.entry_value};

	// Search decisions. In ST_CHECK the read data is the last entry, in ST_SCAN entry i.
	assign rd_v       = $signed(rdata_q.value);
	assign chk_top    = (n_q == CNT_W'(1)) || (s_q >= v0_q);
	assign chk_bottom = s_q <= rd_v;
	assign chk_pair   = n_q == CNT_W'(2);
	assign chk_scan   = !chk_top && !chk_bottom && !chk_pair;
	assign scan_stop  = (s_q > rd_v) || (32'(i_q) == 32'(n_q) - 32'd1);

	// In ST_DECIDE the read data is the entry below the chosen one.
	assign has_below = (32'(idx_q) + 32'd1) < 32'(n_q);
	assign diff_c    = pcl_pkg::DIFF_W'($signed(upper_q.value)) - pcl_pkg::DIFF_W'(rd_v);
	assign off_c     = pcl_pkg::OFF_W'(s_q) - pcl_pkg::OFF_W'(rd_v);
	assign doff_c    = pcl_pkg::DOFF_W'(diff_c) - pcl_pkg::DOFF_W'(off_c);
	assign blend_go  = !upper_q.none && interp_q && has_below && (diff_c != '0) && !rdata_q.none;

	always_comb begin
		blend_req.diff  = diff_c;
		blend_req.off   = off_c;
		blend_req.doff  = doff_c;
		blend_req.above = {upper_q.blue, upper_q.green, upper_q.red};
		blend_req.below = {rdata_q.blue, rdata_q.green, rdata_q.red};
	end

	pcl_blend_unit u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_start),
		.req    (blend_req),
		.rsp    (blend_rsp)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pcl_pkg::ST_IDLE: begin
				if (req_fire && is_lookup)
					state_d = (n_eff == '0) ? pcl_pkg::ST_DONE : pcl_pkg::ST_FIRST;
			end
			pcl_pkg::ST_FIRST:  state_d = pcl_pkg::ST_LAST;
			pcl_pkg::ST_LAST:   state_d = pcl_pkg::ST_CHECK;
			pcl_pkg::ST_CHECK:  state_d = chk_scan ? pcl_pkg::ST_SCAN : pcl_pkg::ST_UPPER;
			pcl_pkg::ST_SCAN:   if (scan_stop) state_d = pcl_pkg::ST_UPPER;
			pcl_pkg::ST_UPPER:  state_d = pcl_pkg::ST_LOWER;
			pcl_pkg::ST_LOWER:  state_d = pcl_pkg::ST_DECIDE;
			pcl_pkg::ST_DECIDE: state_d = blend_go ? pcl_pkg::ST_BLEND : pcl_pkg::ST_DONE;
			pcl_pkg::ST_BLEND:  if (blend_rsp.done) state_d = pcl_pkg::ST_DONE;
			pcl_pkg::ST_DONE:   if (out_load) state_d = pcl_pkg::ST_IDLE;
			default:            state_d = pcl_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: read address, handshake and unit start.
	always_comb begin
		req.ready   = state_q == pcl_pkg::ST_IDLE;
		blend_start = (state_q == pcl_pkg::ST_DECIDE) && blend_go;
		out_load    = (state_q == pcl_pkg::ST_DONE) && (!out_valid_q || rsp.ready);
		case (state_q)
			pcl_pkg::ST_LAST:  raddr = IDX_W'(n_q - CNT_W'(1));
			pcl_pkg::ST_CHECK: raddr = IDX_W'(1);
			pcl_pkg::ST_SCAN:  raddr = i_q + IDX_W'(1);
			pcl_pkg::ST_UPPER: raddr = idx_q;
			pcl_pkg::ST_LOWER: raddr = idx_q + IDX_W'(1);
			default:           raddr = '0;
		endcase
	end

	always_comb begin
		rsp.valid   = out_valid_q;
		rsp.red     = out_red_q;
		rsp.green   = out_green_q;
		rsp.blue    = out_blue_q;
		rsp.alpha   = out_alpha_q;
		rsp.segment = out_seg_q;
	end

	// Palette memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) entry_mem_q[waddr] <= wr_entry;
		rdata_q <= entry_mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= pcl_pkg::ST_IDLE;
			entry_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) entry_count_q <= pwdata[pcl_pkg::COUNT_W-1:0];
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pcl_pkg::ST_IDLE: begin
				if (req_fire && is_lookup) begin
					s_q      <= pcl_pkg::SMP_W'(smp_clamp);
					interp_q <= req.interpolate;
					n_q      <= n_eff;
					// Empty palette: black, opaque, segment zero.
					red_q    <= pcl_pkg::COLOR_ZERO;
					green_q  <= pcl_pkg::COLOR_ZERO;
					blue_q   <= pcl_pkg::COLOR_ZERO;
					alpha_q  <= pcl_pkg::ALPHA_OPAQUE;
					seg_q    <= '0;
				end
			end
			pcl_pkg::ST_LAST: v0_q <= rd_v;
			pcl_pkg::ST_CHECK: begin
				i_q <= IDX_W'(1);
				if (chk_top) begin
					idx_q    <= '0;
					interp_q <= 1'b0;
				end else if (chk_bottom) begin
					idx_q    <= IDX_W'(n_q - CNT_W'(1));
					interp_q <= 1'b0;
				end else if (chk_pair) begin
					idx_q    <= '0;
					interp_q <= 1'b1;
				end
			end
			pcl_pkg::ST_SCAN: begin
				if (scan_stop) idx_q <= i_q - IDX_W'(1);
				else i_q <= i_q + IDX_W'(1);
			end
			pcl_pkg::ST_LOWER: upper_q <= rdata_q;
			pcl_pkg::ST_DECIDE: begin
				seg_q <= pcl_pkg::SEGMENT_W'(idx_q);
				if (upper_q.none) begin
					red_q   <= pcl_pkg::COLOR_ZERO;
					green_q <= pcl_pkg::COLOR_ZERO;
					blue_q  <= pcl_pkg::COLOR_ZERO;
					alpha_q <= pcl_pkg::ALPHA_CLEAR;
				end else begin
					red_q   <= upper_q.red;
					green_q <= upper_q.green;
					blue_q  <= upper_q.blue;
					alpha_q <= pcl_pkg::ALPHA_OPAQUE;
				end
			end
			pcl_pkg::ST_BLEND: begin
				if (blend_rsp.done) begin
					red_q   <= blend_rsp.color[0];
					green_q <= blend_rsp.color[1];
					blue_q  <= blend_rsp.color[2];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_red_q   <= red_q;
			out_green_q <= green_q;
			out_blue_q  <= blue_q;
			out_alpha_q <= alpha_q;
			out_seg_q   <= seg_q;
		end
	end

`ifndef SYNTHESIS
	// The blend unit only finishes while the sequencer waits for it.
	a_blend_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		blend_rsp.done |-> state_q == pcl_pkg::ST_BLEND)
		else $error("blend result arrived outside the blend wait");

	// The scan stays inside the palette and never revisits entry zero.
	a_scan_in_palette: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcl_pkg::ST_SCAN |-> (i_q != '0) && (32'(i_q) < 32'(n_q)))
		else $error("palette scan ran outside the palette");

	// The chosen segment always lies inside the palette.
	a_segment_in_palette: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcl_pkg::ST_DECIDE |-> 32'(idx_q) < 32'(n_q))
		else $error("chosen segment outside the palette");

	// A transparent result carries no color.
	a_clear_is_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_alpha_q == pcl_pkg::ALPHA_CLEAR) |->
		(out_red_q == '0) && (out_green_q == '0) && (out_blue_q == '0))
		else $error("transparent item with nonzero color");
`endif

endmodule
